// ===== src/brb_pkg.sv =====
// shared types, constants and codes for the byte ring buffer
`default_nettype none
package brb_pkg;

  localparam int Depth    = 4096;
  localparam int MaxBlock = 64;
  localparam int AddrW    = $clog2(Depth);
  localparam int CntW     = AddrW + 1;
  localparam int LenW     = 7;
  localparam int FillW    = 13;
  localparam int DataW    = 8;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_DEQ   = 2'd1;
  localparam logic [1:0] MODE_PEEK  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_REJ = 2'd1;
  localparam logic [1:0] ST_CLR = 2'd2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [DataW-1:0] write_data;
    logic [LenW-1:0] block_length;
    logic            block_first;
  } brb_in_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic [1:0]       status;
    logic [LenW-1:0]  byte_count;
    logic             last;
    logic [FillW-1:0] fill_level;
  } brb_out_t;

  // result queue status seen by the core
  typedef struct packed {
    logic [1:0] level;
    logic       pop;
  } brb_oq_stat_t;

endpackage
`default_nettype wire

// ===== src/brb_ram.sv =====
// generic single-port-write, registered-read ram
`default_nettype none
module brb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/brb_outq.sv =====
// two-entry result queue between the core and the output channel
`default_nettype none
module brb_outq
  import brb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire brb_out_t     push_data_i,
  output brb_oq_stat_t      stat_o,
  output logic              out_valid_o,
  input  wire logic         out_stall_i,
  output brb_out_t          out_data_o
);

  brb_out_t   ent_q [2];
  logic       head_q, head_d;
  logic [1:0] count_q, count_d;
  logic       pop;
  logic       wr_idx;

  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign out_data_o  = ent_q[head_q];
  assign wr_idx      = head_q ^ count_q[0];
  assign stat_o.level = count_q;
  assign stat_o.pop   = pop;

  always_comb begin
    head_d  = head_q ^ pop;
    count_d = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_idx] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== src/brb_core.sv =====
// pointer, occupancy and block tracking around the byte memory
`default_nettype none
module brb_core
  import brb_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire brb_in_t      in_data_i,
  input  wire brb_oq_stat_t oq_i,
  output logic              push_o,
  output brb_out_t          push_data_o
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_STREAM = 1'b1;

  logic             state_q, state_d;
  logic [AddrW-1:0] wp_q, wp_d;
  logic [AddrW-1:0] rp_q, rp_d;
  logic [CntW-1:0]  occ_q, occ_d;
  logic [LenW-1:0]  brem_q, brem_d;
  logic             badm_q, badm_d;
  logic [LenW-1:0]  bheld_q, bheld_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [LenW-1:0]  rrem_q, rrem_d;
  logic [LenW-1:0]  rlen_q, rlen_d;
  logic             deq_q, deq_d;
  logic             infl_q, infl_d;
  logic             infl_last_q, infl_last_d;
  logic [CntW-1:0]  infl_fill_q, infl_fill_d;

  logic             acc;
  logic             len_ok;
  logic [CntW:0]    room_sum;
  logic [LenW-1:0]  held_n, rem_n, rem_s;
  logic             adm_n;
  logic             store_ok;
  logic [2:0]       credit;
  logic             issue;
  logic [DataW-1:0] rdata;
  brb_out_t         res;

  assign in_stall_o = (state_q == S_STREAM) || infl_q || (oq_i.level >= 2'd2);
  assign acc        = in_valid_i && !in_stall_o;
  assign len_ok     = (in_data_i.block_length != '0) &&
                      (in_data_i.block_length <= LenW'(MaxBlock));
  assign room_sum   = {1'b0, occ_q} + (CntW+1)'(in_data_i.block_length);
  assign credit     = {1'b0, oq_i.level} + {2'b00, infl_q} - {2'b00, oq_i.pop};
  assign issue      = (state_q == S_STREAM) && (credit < 3'd2);

  // block admission as seen by this write beat
  always_comb begin
    held_n = bheld_q;
    adm_n  = badm_q;
    rem_n  = brem_q;
    if (in_data_i.block_first) begin
      held_n = in_data_i.block_length;
      if (len_ok && (room_sum <= (CntW+1)'(Depth))) begin
        adm_n = 1'b1;
        rem_n = in_data_i.block_length;
      end else begin
        adm_n = 1'b0;
        rem_n = '0;
      end
    end
    store_ok = adm_n && (rem_n != '0) && (occ_q < CntW'(Depth));
    rem_s    = rem_n - LenW'(1);
  end

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    occ_d       = occ_q;
    brem_d      = brem_q;
    badm_d      = badm_q;
    bheld_d     = bheld_q;
    pos_d       = pos_q;
    rrem_d      = rrem_q;
    rlen_d      = rlen_q;
    deq_d       = deq_q;
    infl_d      = issue;
    infl_last_d = infl_last_q;
    infl_fill_d = infl_fill_q;
    push_o      = 1'b0;
    res         = '0;
    res.last    = 1'b1;
    res.status  = ST_REJ;
    res.fill_level = FillW'(occ_q);

    if (acc) begin
      push_o = 1'b1;
      case (in_data_i.mode)
        MODE_WRITE: begin
          bheld_d = held_n;
          badm_d  = adm_n;
          brem_d  = rem_n;
          if (store_ok) begin
            wp_d   = wp_q + AddrW'(1);
            occ_d  = occ_q + CntW'(1);
            brem_d = rem_s;
            badm_d = (rem_s != '0);
            res.status     = ST_OK;
            res.byte_count = held_n - rem_s;
            res.fill_level = FillW'(occ_q + CntW'(1));
          end
        end
        MODE_CLEAR: begin
          wp_d    = '0;
          rp_d    = '0;
          occ_d   = '0;
          brem_d  = '0;
          badm_d  = 1'b0;
          bheld_d = '0;
          res.status     = ST_CLR;
          res.fill_level = '0;
        end
        default: begin
          // dequeue or peek: reject at once, or hand over to the stream
          if (len_ok && (occ_q >= CntW'(in_data_i.block_length))) begin
            push_o  = 1'b0;
            state_d = S_STREAM;
            pos_d   = rp_q;
            rrem_d  = in_data_i.block_length;
            rlen_d  = in_data_i.block_length;
            deq_d   = (in_data_i.mode == MODE_DEQ);
          end
        end
      endcase
    end

    if (issue) begin
      pos_d       = pos_q + AddrW'(1);
      rrem_d      = rrem_q - LenW'(1);
      infl_last_d = (rrem_q == LenW'(1));
      infl_fill_d = occ_q;
      if (deq_q) begin
        rp_d        = pos_q + AddrW'(1);
        occ_d       = occ_q - CntW'(1);
        infl_fill_d = occ_q - CntW'(1);
      end
      if (rrem_q == LenW'(1)) begin
        state_d = S_IDLE;
      end
    end

    // read data lands in the cycle after the address is issued
    if (infl_q) begin
      push_o         = 1'b1;
      res.read_data  = rdata;
      res.status     = ST_OK;
      res.byte_count = rlen_q;
      res.last       = infl_last_q;
      res.fill_level = FillW'(infl_fill_q);
    end
  end

  assign push_data_o = res;

  brb_ram #(
    .Width(DataW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (acc && (in_data_i.mode == MODE_WRITE) && store_ok),
    .waddr_i(wp_q),
    .wdata_i(in_data_i.write_data),
    .re_i   (issue),
    .raddr_i(pos_q),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wp_q    <= '0;
      rp_q    <= '0;
      occ_q   <= '0;
      brem_q  <= '0;
      badm_q  <= 1'b0;
      bheld_q <= '0;
      rrem_q  <= '0;
      infl_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      occ_q   <= occ_d;
      brem_q  <= brem_d;
      badm_q  <= badm_d;
      bheld_q <= bheld_d;
      rrem_q  <= rrem_d;
      infl_q  <= infl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    rlen_q      <= rlen_d;
    deq_q       <= deq_d;
    infl_last_q <= infl_last_d;
    infl_fill_q <= infl_fill_d;
  end

endmodule
`default_nettype wire

// ===== src/byte_ring_buffer_block_transfer.sv =====
// byte ring buffer with all-or-nothing block writes and block reads
// write, clear and rejected beats: result valid in the cycle after acceptance, one beat per
//   cycle unless the input stalls; dequeue/peek of n bytes pass the stream state, the registered
//   read and the result queue, one byte per cycle as the output drains; the next beat is not
//   taken before the last byte is read; pace is set by the single read port of the byte memory
// reset clears pointers, occupancy and block tracking; byte memory contents are not cleared
`default_nettype none
module byte_ring_buffer_block_transfer
  import brb_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire brb_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output brb_out_t      out_data_o
);

  brb_oq_stat_t oq_stat;
  logic         push;
  brb_out_t     push_data;

  brb_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .oq_i       (oq_stat),
    .push_o     (push),
    .push_data_o(push_data)
  );

  brb_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .stat_o     (oq_stat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

// ===== src/brb_checker.sv =====
// port-level checks for the byte ring buffer
`default_nettype none
module brb_port_checks
  import brb_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     in_valid_i,
  input wire logic     in_stall_o,
  input wire brb_in_t  in_data_i,
  input wire logic     out_valid_o,
  input wire logic     out_stall_i,
  input wire brb_out_t out_data_o
);

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result payload changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK) || (out_data_o.status == ST_REJ) ||
                    (out_data_o.status == ST_CLR))
    else $error("unknown status code");

  a_reject_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_REJ) |->
      out_data_o.last && (out_data_o.byte_count == '0) && (out_data_o.read_data == '0))
    else $error("rejected beat not single and empty");

  a_clear_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == ST_CLR) |->
      out_data_o.last && (out_data_o.fill_level == '0))
    else $error("clear beat with stored bytes");

endmodule

bind byte_ring_buffer_block_transfer brb_port_checks u_brb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
`default_nettype wire
